[rtl/core/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, codes and types of the k-way sorted run merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int RUNS      = 8;
  localparam int RUN_DEPTH = 256;

  localparam int KEY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int SEL_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int SRC_W     = 3;
  localparam int RUN_IDX_W = $clog2(RUNS);
  localparam int SCAN_W    = $clog2(RUNS);
  localparam int SLOT_W    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

  localparam int IN_FIELDS_W  = CMD_W + SEL_W + KEY_W;
  localparam int OUT_FIELDS_W = STATUS_W + KEY_W + SRC_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } kwm_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } kwm_status_e;

  // Partial result that travels down the row of run cells.
  typedef struct packed {
    logic                    found;
    logic signed [KEY_W-1:0] key;
    logic [RUN_IDX_W-1:0]    run;
  } kwm_chain_t;

  // Per-cell commands issued by the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } kwm_cell_ctrl_t;

  function automatic logic [SLOT_W-1:0] kwm_slot_inc(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] nxt;
    if (slot == SLOT_W'(RUN_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = slot + SLOT_W'(1);
    end
    return nxt;
  endfunction

endpackage

[rtl/core/kwm_cell.sv]
// ----------------------------------------------------------------------------
// kwm_cell
// One sorted run: its FIFO storage, pointers, registered head and one
// compare stage of the minimum chain.
// ----------------------------------------------------------------------------
module kwm_cell
  import kwm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [RUN_IDX_W-1:0]    cell_idx_i,
  input  kwm_cell_ctrl_t          ctrl_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  kwm_chain_t              chain_i,
  output kwm_chain_t              chain_o,
  output logic                    full_o
);

  logic [KEY_W-1:0]        mem [RUN_DEPTH];
  logic [SLOT_W-1:0]       rd_slot_q, rd_slot_d;
  logic [SLOT_W-1:0]       wr_slot_q, wr_slot_d;
  logic                    rd_wrap_q, rd_wrap_d;
  logic                    wr_wrap_q, wr_wrap_d;
  logic signed [KEY_W-1:0] head_q;
  kwm_chain_t              chain_q, chain_d;
  logic                    empty;
  logic                    take;

  // A wrap bit beside each slot tells a full run from an empty one.
  assign empty  = (rd_slot_q == wr_slot_q) && (rd_wrap_q == wr_wrap_q);
  assign full_o = (rd_slot_q == wr_slot_q) && (rd_wrap_q != wr_wrap_q);

  always_comb begin
    rd_slot_d = rd_slot_q;
    rd_wrap_d = rd_wrap_q;
    wr_slot_d = wr_slot_q;
    wr_wrap_d = wr_wrap_q;
    if (ctrl_i.clear) begin
      rd_slot_d = '0;
      rd_wrap_d = 1'b0;
      wr_slot_d = '0;
      wr_wrap_d = 1'b0;
    end else if (ctrl_i.push) begin
      wr_slot_d = kwm_slot_inc(wr_slot_q);
      wr_wrap_d = wr_wrap_q ^ (wr_slot_q == SLOT_W'(RUN_DEPTH - 1));
    end else if (ctrl_i.pop) begin
      rd_slot_d = kwm_slot_inc(rd_slot_q);
      rd_wrap_d = rd_wrap_q ^ (rd_slot_q == SLOT_W'(RUN_DEPTH - 1));
    end
  end

  // Strict less-than keeps the earlier (lower) run on equal keys.
  assign take = !empty && (!chain_i.found || (head_q < chain_i.key));

  always_comb begin
    chain_d = chain_i;
    if (take) begin
      chain_d.found = 1'b1;
      chain_d.key   = head_q;
      chain_d.run   = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      rd_wrap_q <= 1'b0;
      wr_slot_q <= '0;
      wr_wrap_q <= 1'b0;
      chain_q   <= '0;
    end else begin
      rd_slot_q <= rd_slot_d;
      rd_wrap_q <= rd_wrap_d;
      wr_slot_q <= wr_slot_d;
      wr_wrap_q <= wr_wrap_d;
      chain_q   <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_slot_q] <= key_i;
    end
    head_q <= mem[rd_slot_q];
  end

  assign chain_o = chain_q;

endmodule

[rtl/core/k_way_sorted_run_merge.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_run_merge
// Holds RUNS sorted runs of signed keys and pops the smallest head on demand.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time. A push or a clear passes through
// S_EXEC and S_FINISH before the next beat is accepted; a pop passes through
// S_SCAN, S_COMMIT and S_FINISH, because the minimum travels down a row of RUNS
// run cells, one registered compare stage per run, and the head of the run that
// was popped is then read back from its storage into a register. The result
// beat waits in an output register, so a new command is taken while the
// previous result is still held back by the consumer.
// ----------------------------------------------------------------------------
module k_way_sorted_run_merge
  import kwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] command, [4:2] run_select, [36:5] key_in, upper bits zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [33:2] key_out, [36:34] source_run, upper bits zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_COMMIT,
    S_FINISH
  } state_e;

  state_e                  state_q;
  logic [CMD_W-1:0]        cmd_q;
  logic [SEL_W-1:0]        sel_q;
  logic signed [KEY_W-1:0] key_q;
  logic [SCAN_W-1:0]       scan_cnt_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic [KEY_W-1:0]        res_key_q;
  logic [SRC_W-1:0]        res_run_q;
  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  m_tdata_q;

  kwm_cell_ctrl_t ctrl  [RUNS];
  kwm_chain_t     chain [RUNS];
  logic [RUNS-1:0] full_vec;
  logic [RUNS-1:0] sel_match;
  logic [RUNS-1:0] run_match;
  kwm_chain_t      best;
  logic            push_drop;
  logic            accept;

  assign best   = chain[RUNS-1];
  assign accept = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < RUNS; i++) begin : g_cell
    kwm_chain_t chain_in;

    assign sel_match[i]  = (32'(sel_q) == 32'(i));
    assign run_match[i]  = (32'(best.run) == 32'(i));
    assign ctrl[i].push  = (state_q == S_EXEC) && (cmd_q == CMD_PUSH) &&
                           sel_match[i] && !full_vec[i];
    assign ctrl[i].clear = (state_q == S_EXEC) && (cmd_q == CMD_CLEAR);
    assign ctrl[i].pop   = (state_q == S_COMMIT) && best.found && run_match[i];

    if (i == 0) begin : g_head
      assign chain_in = '0;
    end else begin : g_link
      assign chain_in = chain[i-1];
    end

    kwm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (RUN_IDX_W'(i)),
      .ctrl_i     (ctrl[i]),
      .key_i      (key_q),
      .chain_i    (chain_in),
      .chain_o    (chain[i]),
      .full_o     (full_vec[i])
    );
  end

  // A push to a run that does not exist or that is full is dropped.
  assign push_drop = !(|sel_match) || (|(sel_match & full_vec));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      sel_q        <= '0;
      key_q        <= '0;
      scan_cnt_q   <= '0;
      res_status_q <= '0;
      res_key_q    <= '0;
      res_run_q    <= '0;
      m_valid_q    <= 1'b0;
      m_tdata_q    <= '0;
    end else begin
      // In S_FINISH the output register is handled by the state itself.
      if (m_valid_q && m_axis_tready && (state_q != S_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= s_axis_tdata[CMD_W-1:0];
            sel_q      <= s_axis_tdata[CMD_W +: SEL_W];
            key_q      <= s_axis_tdata[CMD_W+SEL_W +: KEY_W];
            scan_cnt_q <= '0;
            if (s_axis_tdata[CMD_W-1:0] == CMD_POP) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          res_key_q <= '0;
          res_run_q <= '0;
          if ((cmd_q == CMD_PUSH) && push_drop) begin
            res_status_q <= ST_DROPPED;
          end else begin
            res_status_q <= ST_DONE;
          end
          state_q <= S_FINISH;
        end
        S_SCAN: begin
          // The heads are stable here, so the whole chain settles before S_COMMIT.
          if (scan_cnt_q == SCAN_W'(RUNS - 1)) begin
            state_q <= S_COMMIT;
          end else begin
            scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
          end
        end
        S_COMMIT: begin
          if (best.found) begin
            res_status_q <= ST_POPPED;
            res_key_q    <= best.key;
            res_run_q    <= SRC_W'(best.run);
          end else begin
            res_status_q <= ST_EMPTY;
            res_key_q    <= '0;
            res_run_q    <= '0;
          end
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          // This cycle also lets the refreshed head land in its register.
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_tdata_q <= OUT_TDATA_W'({res_run_q, res_key_q, res_status_q});
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-way sorted run merge. A class keeps its own
// copy of the runs, predicts the status, key and source run of every command
// beat that the block accepts, and checks each result beat in order. Stimulus
// is a short directed part followed by a run fill, random merge sequences, noise and
// broken sequences, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;
  import kwm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PTR_WRAP    = 2 * RUN_DEPTH;
  localparam int MAX_REPORTS = 100;
  localparam int POP_CYCLES  = RUNS + 3;

  typedef struct {
    kwm_status_e             status;
    logic signed [KEY_W-1:0] key;
    logic [SRC_W-1:0]        src;
  } merge_outcome_t;

  class merge_checker;
    logic signed [KEY_W-1:0] run_keys [RUNS][RUN_DEPTH];
    int unsigned             head_ptr [RUNS];
    int unsigned             tail_ptr [RUNS];
    merge_outcome_t          outcomes_due [$];
    int                      errors;
    int                      reports;

    function new();
      errors  = 0;
      reports = 0;
      for (int r = 0; r < RUNS; r++) begin
        head_ptr[r] = 0;
        tail_ptr[r] = 0;
      end
    endfunction

    function int unsigned level(int r);
      return (tail_ptr[r] + PTR_WRAP - head_ptr[r]) % PTR_WRAP;
    endfunction

    function int unsigned occupancy();
      int unsigned total;
      total = 0;
      for (int r = 0; r < RUNS; r++) begin
        total += level(r);
      end
      return total;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    // Applies one accepted command to the local runs and queues its outcome.
    function void note_beat(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                            logic signed [KEY_W-1:0] key);
      merge_outcome_t res;
      bit             found;
      int             best_run;
      int             s;
      res.status = ST_DONE;
      res.key    = '0;
      res.src    = '0;
      found      = 1'b0;
      best_run   = 0;
      s          = int'(sel);
      case (cmd)
        CMD_PUSH: begin
          if (s >= RUNS || level(s) >= RUN_DEPTH) begin
            res.status = ST_DROPPED;
          end else begin
            run_keys[s][tail_ptr[s] % RUN_DEPTH] = key;
            tail_ptr[s] = (tail_ptr[s] + 1) % PTR_WRAP;
          end
        end
        CMD_POP: begin
          // Strict less-than keeps the lowest run index on equal keys.
          for (int r = 0; r < RUNS; r++) begin
            if (level(r) != 0 &&
                (!found || run_keys[r][head_ptr[r] % RUN_DEPTH] < res.key)) begin
              res.key  = run_keys[r][head_ptr[r] % RUN_DEPTH];
              best_run = r;
              found    = 1'b1;
            end
          end
          if (found) begin
            head_ptr[best_run] = (head_ptr[best_run] + 1) % PTR_WRAP;
            res.status = ST_POPPED;
            res.src    = SRC_W'(best_run);
          end else begin
            res.status = ST_EMPTY;
            res.key    = '0;
          end
        end
        CMD_CLEAR: begin
          for (int r = 0; r < RUNS; r++) begin
            head_ptr[r] = 0;
            tail_ptr[r] = 0;
          end
        end
        default: begin
        end
      endcase
      outcomes_due.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      merge_outcome_t          want;
      kwm_status_e             got_status;
      logic signed [KEY_W-1:0] got_key;
      logic [SRC_W-1:0]        got_src;
      got_status = kwm_status_e'(beat[STATUS_W-1:0]);
      got_key    = beat[STATUS_W +: KEY_W];
      got_src    = beat[STATUS_W + KEY_W +: SRC_W];
      if (outcomes_due.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: result beat with nothing expected: status %0d key %0d run %0d",
                   $time, got_status, got_key, got_src);
        end
        return;
      end
      want = outcomes_due.pop_front();
      if (got_status !== want.status || got_key !== want.key || got_src !== want.src) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: expected status %0d key %0d run %0d, got status %0d key %0d run %0d",
                   $time, want.status, want.key, want.src, got_status, got_key, got_src);
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [1:0] command, [4:2] run_select, [36:5] key_in, upper bits zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [1:0] status, [33:2] key_out, [36:34] source_run, upper bits zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  merge_checker sb;
  int           idle_pct   = 0;
  int           stall_pct  = 0;
  int           beats_sent = 0;

  k_way_sorted_run_merge uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Offers one command beat, with random sender gaps, and waits until it is taken.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                           input logic signed [KEY_W-1:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({key, sel, cmd});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(cmd, sel, key);
    beats_sent++;
  endtask

  // Pops until every run is empty, then once more to see the empty status.
  task automatic drain_runs();
    while (sb.occupancy() != 0) begin
      send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    end
    send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
  endtask

  // Non-decreasing keys into a random group of runs, with occasional early pops.
  task automatic merge_episode();
    logic signed [KEY_W-1:0] tail_key [RUNS];
    logic signed [KEY_W-1:0] base;
    longint                  next_key;
    int                      pushes;
    int                      live_runs;
    int                      offset;
    int                      step;
    int                      r;
    pushes    = $urandom_range(1, 40);
    live_runs = $urandom_range(1, RUNS);
    offset    = $urandom_range(RUNS - 1);
    case ($urandom_range(3))
      0:       step = 0;
      1:       step = 3;
      2:       step = 1000;
      default: step = 1 << 24;
    endcase
    case ($urandom_range(3))
      0:       base = KEY_W'($urandom);
      1:       base = 32'sh8000_0000 + KEY_W'($urandom_range(100));
      2:       base = 32'sh7fff_ffff - KEY_W'($urandom_range(100));
      default: base = KEY_W'($urandom_range(200)) - 32'sd100;
    endcase
    for (int i = 0; i < RUNS; i++) begin
      tail_key[i] = base;
    end
    if ($urandom_range(1) == 0) begin
      send_beat(CMD_CLEAR, SEL_W'($urandom), KEY_W'($urandom));
    end
    for (int i = 0; i < pushes; i++) begin
      r = (offset + $urandom_range(live_runs - 1)) % RUNS;
      next_key = longint'(tail_key[r]) + longint'($urandom_range(step));
      if (next_key > 64'sd2147483647) begin
        next_key = 64'sd2147483647;
      end
      tail_key[r] = next_key[KEY_W-1:0];
      send_beat(CMD_PUSH, SEL_W'(r), tail_key[r]);
      if ($urandom_range(99) < 20) begin
        send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
      end
    end
    if ($urandom_range(99) < 15) begin
      send_beat(CMD_CLEAR, SEL_W'($urandom), KEY_W'($urandom));
    end
    drain_runs();
  endtask

  task automatic noise_episode();
    int n;
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_W'($urandom_range(3)), SEL_W'($urandom), KEY_W'($urandom));
    end
  endtask

  // Unsorted pushes cut short by a clear, then a pop into empty runs and at times a push and a drain.
  task automatic broken_episode();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_PUSH, SEL_W'($urandom), KEY_W'($urandom));
    end
    if ($urandom_range(1) == 0) begin
      send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    end
    send_beat(CMD_CLEAR, SEL_W'($urandom), KEY_W'($urandom));
    send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    if ($urandom_range(1) == 0) begin
      send_beat(CMD_PUSH, SEL_W'($urandom), KEY_W'($urandom));
      drain_runs();
    end
  endtask

  // Fills one run, refills it across the slot wrap, and pushes into it while full.
  task automatic fill_episode();
    logic signed [KEY_W-1:0] key;
    int                      r;
    r   = $urandom_range(RUNS - 1);
    key = KEY_W'($urandom_range(1 << 20));
    send_beat(CMD_CLEAR, SEL_W'($urandom), KEY_W'($urandom));
    for (int i = 0; i < RUN_DEPTH; i++) begin
      send_beat(CMD_PUSH, SEL_W'(r), key);
      key = key + KEY_W'($urandom_range(2));
    end
    send_beat(CMD_PUSH, SEL_W'(r), key);
    send_beat(CMD_PUSH, SEL_W'((r + 1) % RUNS), key - 32'sd1);
    for (int i = 0; i < RUN_DEPTH / 2; i++) begin
      send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    end
    for (int i = 0; i < RUN_DEPTH / 2; i++) begin
      send_beat(CMD_PUSH, SEL_W'(r), key);
      key = key + KEY_W'($urandom_range(2));
    end
    send_beat(CMD_PUSH, SEL_W'(r), key);
    drain_runs();
  endtask

  initial begin
    int goal;
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, the unused command, key extremes, a tie and a clear.
    send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    send_beat(CMD_UNUSED, SEL_W'($urandom), KEY_W'($urandom));
    send_beat(CMD_PUSH, 3'd0, 32'sh7fff_ffff);
    send_beat(CMD_PUSH, 3'd7, 32'sh8000_0000);
    send_beat(CMD_PUSH, 3'd3, 32'sd0);
    send_beat(CMD_PUSH, 3'd5, -32'sd1);
    send_beat(CMD_PUSH, 3'd1, 32'sd0);
    send_beat(CMD_PUSH, 3'd2, 32'sd5);
    send_beat(CMD_UNUSED, 3'd7, 32'shffff_ffff);
    for (int i = 0; i < 7; i++) begin
      send_beat(CMD_POP, SEL_W'($urandom), KEY_W'($urandom));
    end
    send_beat(CMD_PUSH, 3'd4, 32'sd10);
    send_beat(CMD_PUSH, 3'd6, 32'sd10);
    send_beat(CMD_CLEAR, 3'd7, 32'shffff_ffff);
    send_beat(CMD_POP, 3'd0, 32'sd0);
    send_beat(CMD_PUSH, 3'd6, 32'sd1);
    send_beat(CMD_POP, 3'd0, 32'sd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;  goal = 850;
        end
        1: begin
          idle_pct = 79; stall_pct = 0;  goal = 1080;
        end
        2: begin
          idle_pct = 0;  stall_pct = 79; goal = 1310;
        end
        default: begin
          idle_pct = 18; stall_pct = 18; goal = 1550;
        end
      endcase
      if (ph == 0) begin
        fill_episode();
      end
      while (beats_sent < goal) begin
        case ($urandom_range(99)) inside
          [0:64]:  merge_episode();
          [65:84]: noise_episode();
          default: broken_episode();
        endcase
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4 * POP_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
